// File: src/rbtg_pkg.sv
// Shared types, constants and the arctangent table for the range and bearing target gate.
// No dependencies; every other file of the block imports this package.
package rbtg_pkg;

  // Default sizes, handed to the top level as parameter defaults.
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int POS_BITS_DEF      = 16;

  // Positions are scaled by 2^GUARD_SHIFT before the rotation steps.
  localparam int GUARD_SHIFT = 24;
  // Number of entries in the arctangent table; more stages than this are not built.
  localparam int ATAN_LEN    = 24;
  // Angle accumulator width, 2^32 units per turn.
  localparam int ANG_W       = 32;

  // Configuration port sizes.
  localparam int CFG_W      = 16;
  localparam int CFG_ADDR_W = 2;

  // Result stream width: 19 payload bits padded to three bytes.
  localparam int OUT_TDATA_W = 24;

  // Register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_CONF_FLOOR  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_RANGE   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_REF_BEARING = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_OFFSET  = 2'd3;

  // Register reset values.
  localparam logic [CFG_W-1:0] CONF_FLOOR_RESET  = 16'd0;
  localparam logic [CFG_W-1:0] MAX_RANGE_RESET   = 16'd8000;
  localparam logic [CFG_W-1:0] REF_BEARING_RESET = 16'd0;
  localparam logic [CFG_W-1:0] MAX_OFFSET_RESET  = 16'd32768;
  localparam logic [31:0]      LIM2_RESET        = 32'd64000000;

  // Reject causes.
  localparam logic [1:0] CAUSE_NONE    = 2'd0;
  localparam logic [1:0] CAUSE_CONF    = 2'd1;
  localparam logic [1:0] CAUSE_RANGE   = 2'd2;
  localparam logic [1:0] CAUSE_BEARING = 2'd3;

  // Half a turn in accumulator units, the start angle for the left half plane.
  localparam logic [ANG_W-1:0] ANGLE_HALF_TURN = 32'h8000_0000;

  // atan(2^-i) in units of 2^32 per turn, truncated.
  localparam logic [ANG_W-1:0] ATAN_TAB [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  // Gate flags that travel alongside the rotation pipeline.
  typedef struct packed {
    logic conf_low;
    logic far;
    logic origin;
  } gate_flags_t;

  // One finished verdict.
  typedef struct packed {
    logic        accepted;
    logic [1:0]  reject_cause;
    logic [15:0] bearing_offset;
  } verdict_t;

endpackage

// File: src/rbtg_prep.sv
// Front end of the gate: half-plane fold, squared distance and the confidence and range tests.
// Depends on rbtg_pkg. Three register stages, all held while en is low.
module rbtg_prep #(
  parameter int POS_BITS = rbtg_pkg::POS_BITS_DEF,
  parameter int W        = rbtg_pkg::POS_BITS_DEF + rbtg_pkg::GUARD_SHIFT + 3
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             valid_i,
  input  logic [15:0]                      conf_i,
  input  logic signed [POS_BITS-1:0]       px_i,
  input  logic signed [POS_BITS-1:0]       py_i,
  input  logic signed [POS_BITS-1:0]       pz_i,
  input  logic [15:0]                      conf_floor_i,
  input  logic [31:0]                      lim2_i,
  output logic                             valid_o,
  output rbtg_pkg::gate_flags_t            flags_o,
  output logic signed [W-1:0]              x_o,
  output logic signed [W-1:0]              y_o,
  output logic [rbtg_pkg::ANG_W-1:0]       acc_o
);
  import rbtg_pkg::*;

  localparam int SQ_W = 2 * POS_BITS;
  localparam int DW   = 2 * POS_BITS + 2;
  localparam int CW   = (DW > 32) ? DW : 32;

  logic                   vld1_r, vld2_r, vld3_r;
  logic signed [W-1:0]    px_w, py_w;
  logic [POS_BITS-1:0]    ax, ay, az;
  logic signed [W-1:0]    x1_nxt, y1_nxt;
  logic [ANG_W-1:0]       acc1_nxt;
  logic signed [W-1:0]    x1_r, y1_r, x2_r, y2_r, x3_r, y3_r;
  logic [ANG_W-1:0]       acc1_r, acc2_r, acc3_r;
  logic                   org1_r, org2_r;
  logic [15:0]            conf1_r, conf2_r;
  logic [SQ_W-1:0]        sqx1_r, sqy1_r, sqz1_r;
  logic [DW-1:0]          dist2_nxt, dist2_r;
  gate_flags_t            flags3_nxt, flags3_r;

  // Scale the position and fold the left half plane onto the right one.
  always_comb begin
    px_w = {{(W-POS_BITS-GUARD_SHIFT){px_i[POS_BITS-1]}}, px_i, {GUARD_SHIFT{1'b0}}};
    py_w = {{(W-POS_BITS-GUARD_SHIFT){py_i[POS_BITS-1]}}, py_i, {GUARD_SHIFT{1'b0}}};
    if (px_i[POS_BITS-1]) begin
      x1_nxt   = -px_w;
      y1_nxt   = -py_w;
      acc1_nxt = ANGLE_HALF_TURN;
    end else begin
      x1_nxt   = px_w;
      y1_nxt   = py_w;
      acc1_nxt = '0;
    end
    ax = px_i[POS_BITS-1] ? (~px_i + POS_BITS'(1)) : px_i;
    ay = py_i[POS_BITS-1] ? (~py_i + POS_BITS'(1)) : py_i;
    az = pz_i[POS_BITS-1] ? (~pz_i + POS_BITS'(1)) : pz_i;
  end

  // Sum of squares and the two threshold tests.
  always_comb begin
    dist2_nxt           = DW'(sqx1_r) + DW'(sqy1_r) + DW'(sqz1_r);
    flags3_nxt.conf_low = (conf2_r < conf_floor_i);
    flags3_nxt.far      = (CW'(dist2_r) > CW'(lim2_i));
    flags3_nxt.origin   = org2_r;
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else if (en) begin
      vld1_r <= valid_i;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  // Payload of the three stages.
  always_ff @(posedge clk) begin
    if (en) begin
      x1_r     <= x1_nxt;
      y1_r     <= y1_nxt;
      acc1_r   <= acc1_nxt;
      org1_r   <= (px_i == '0) && (py_i == '0);
      conf1_r  <= conf_i;
      sqx1_r   <= SQ_W'(ax) * SQ_W'(ax);
      sqy1_r   <= SQ_W'(ay) * SQ_W'(ay);
      sqz1_r   <= SQ_W'(az) * SQ_W'(az);
      x2_r     <= x1_r;
      y2_r     <= y1_r;
      acc2_r   <= acc1_r;
      org2_r   <= org1_r;
      conf2_r  <= conf1_r;
      dist2_r  <= dist2_nxt;
      x3_r     <= x2_r;
      y3_r     <= y2_r;
      acc3_r   <= acc2_r;
      flags3_r <= flags3_nxt;
    end
  end

  assign valid_o = vld3_r;
  assign flags_o = flags3_r;
  assign x_o     = x3_r;
  assign y_o     = y3_r;
  assign acc_o   = acc3_r;

endmodule

// File: src/rbtg_cordic.sv
// Pipelined vectoring CORDIC: one micro-rotation per register stage, angle in binary units.
// Depends on rbtg_pkg for the arctangent table and the flag struct.
module rbtg_cordic #(
  parameter int W      = rbtg_pkg::POS_BITS_DEF + rbtg_pkg::GUARD_SHIFT + 3,
  parameter int STAGES = rbtg_pkg::CORDIC_STAGES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        valid_i,
  input  rbtg_pkg::gate_flags_t       flags_i,
  input  logic signed [W-1:0]         x_i,
  input  logic signed [W-1:0]         y_i,
  input  logic [rbtg_pkg::ANG_W-1:0]  acc_i,
  output logic                        valid_o,
  output rbtg_pkg::gate_flags_t       flags_o,
  output logic [rbtg_pkg::ANG_W-1:0]  acc_o
);
  import rbtg_pkg::*;

  // Stages beyond the table length are not built.
  localparam int NSTG = (STAGES > ATAN_LEN) ? ATAN_LEN : STAGES;

  logic                vld_r   [NSTG];
  gate_flags_t         flg_r   [NSTG];
  logic signed [W-1:0] x_r     [NSTG];
  logic signed [W-1:0] y_r     [NSTG];
  logic [ANG_W-1:0]    acc_r   [NSTG];

  for (genvar i = 0; i < NSTG; i++) begin : g_stage
    logic                vld_prev;
    gate_flags_t         flg_prev;
    logic signed [W-1:0] x_prev, y_prev, xs, ys, x_nxt, y_nxt;
    logic [ANG_W-1:0]    acc_prev, acc_nxt;
    logic                y_pos;

    // Stage input: the pipeline input for the first stage, else the stage before.
    if (i == 0) begin : g_first
      assign vld_prev = valid_i;
      assign flg_prev = flags_i;
      assign x_prev   = x_i;
      assign y_prev   = y_i;
      assign acc_prev = acc_i;
    end else begin : g_next
      assign vld_prev = vld_r[i-1];
      assign flg_prev = flg_r[i-1];
      assign x_prev   = x_r[i-1];
      assign y_prev   = y_r[i-1];
      assign acc_prev = acc_r[i-1];
    end

    // Rotate toward the x axis; a zero y counts as not positive.
    always_comb begin
      xs    = x_prev >>> i;
      ys    = y_prev >>> i;
      y_pos = !y_prev[W-1] && (y_prev != '0);
      if (y_pos) begin
        x_nxt   = x_prev + ys;
        y_nxt   = y_prev - xs;
        acc_nxt = acc_prev + ATAN_TAB[i];
      end else begin
        x_nxt   = x_prev - ys;
        y_nxt   = y_prev + xs;
        acc_nxt = acc_prev - ATAN_TAB[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        flg_r[i] <= flg_prev;
        x_r[i]   <= x_nxt;
        y_r[i]   <= y_nxt;
        acc_r[i] <= acc_nxt;
      end
    end
  end

  assign valid_o = vld_r[NSTG-1];
  assign flags_o = flg_r[NSTG-1];
  assign acc_o   = acc_r[NSTG-1];

endmodule

// File: src/rbtg_verdict.sv
// Bearing rounding, wrapped offset from the reference, and the final reject decision.
// Depends on rbtg_pkg. One register stage; the decision itself feeds the output buffer.
module rbtg_verdict (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        valid_i,
  input  rbtg_pkg::gate_flags_t       flags_i,
  input  logic [rbtg_pkg::ANG_W-1:0]  acc_i,
  input  logic [15:0]                 ref_bearing_i,
  input  logic [15:0]                 max_offset_i,
  output logic                        valid_o,
  output rbtg_pkg::verdict_t          result_o
);
  import rbtg_pkg::*;

  logic [15:0] bearing, diff, offset_nxt, offset_r;
  logic        vld_r;
  gate_flags_t flags_r;
  logic [1:0]  cause;

  // Round the angle to 16 bits and take the absolute wrapped difference.
  always_comb begin
    bearing    = flags_i.origin ? 16'd0 : (acc_i[ANG_W-1:ANG_W-16] + 16'(acc_i[ANG_W-17]));
    diff       = bearing - ref_bearing_i;
    offset_nxt = diff[15] ? (~diff + 16'd1) : diff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flags_r  <= flags_i;
      offset_r <= offset_nxt;
    end
  end

  // Confidence first, then range, then bearing.
  always_comb begin
    if (flags_r.conf_low) begin
      cause = CAUSE_CONF;
    end else if (flags_r.far) begin
      cause = CAUSE_RANGE;
    end else if (offset_r > max_offset_i) begin
      cause = CAUSE_BEARING;
    end else begin
      cause = CAUSE_NONE;
    end
    result_o.accepted       = (cause == CAUSE_NONE);
    result_o.reject_cause   = cause;
    result_o.bearing_offset = offset_r;
  end

  assign valid_o = vld_r;

endmodule

// File: src/rbtg_outbuf.sv
// Output register with a one-entry skid buffer for the result stream.
// Depends on rbtg_pkg. Its ready is registered and holds the whole pipeline when low.
module rbtg_outbuf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid_i,
  input  rbtg_pkg::verdict_t push_data_i,
  output logic               ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rbtg_pkg::verdict_t out_data_o
);
  import rbtg_pkg::*;

  logic     out_valid_r, skid_valid_r;
  verdict_t out_data_r, skid_data_r;
  logic     push, pop;

  assign push = push_valid_i && !skid_valid_r;
  assign pop  = out_valid_r && out_ready_i;

  // Fill the output register first; park a transaction in the skid entry when it is held.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_data_r <= push_data_i;
      end else begin
        out_data_r <= push_data_i;
      end
    end
  end

  assign ready_o     = !skid_valid_r;
  assign out_valid_o = out_valid_r;
  assign out_data_o  = out_data_r;

endmodule

// File: src/range_bearing_target_gate.sv
// Top level of the range and bearing target gate: configuration registers and stream ports.
// Depends on rbtg_pkg, rbtg_prep, rbtg_cordic, rbtg_verdict and rbtg_outbuf.
//
// Every target transaction on the input stream yields exactly one verdict on the output
// stream, in order. The block takes one target per clock while in_tready is high;
// a target passes three front-end stages for the squared distance and the threshold
// tests, one stage per CORDIC micro-rotation, at most 24, one stage for the bearing
// offset, and the output register. The output register has a one-entry skid buffer
// behind it, so in_tready falls only when a result is held and a second one is parked;
// the whole pipeline then holds. Configuration takes effect for targets sent after the
// write; write only while no target is in flight. No clearing pass after reset.
module range_bearing_target_gate #(
  parameter int CORDIC_STAGES = rbtg_pkg::CORDIC_STAGES_DEF,
  parameter int POS_BITS      = rbtg_pkg::POS_BITS_DEF,
  localparam int IN_TDATA_W   = ((16 + 3 * POS_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input stream, tdata from bit 0 up: confidence[15:0], pos_x, pos_y, pos_z
  // (POS_BITS each, signed), zero padding.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [IN_TDATA_W-1:0]           in_tdata,
  // Result stream, tdata from bit 0 up: accepted, reject_cause[1:0],
  // bearing_offset[15:0], zero padding.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rbtg_pkg::OUT_TDATA_W-1:0] out_tdata,
  // Configuration write port.
  input  logic                            cfg_wr_en,
  input  logic [rbtg_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [rbtg_pkg::CFG_W-1:0]      cfg_wdata
);
  import rbtg_pkg::*;

  localparam int CORDIC_W = POS_BITS + GUARD_SHIFT + 3;

  logic [CFG_W-1:0] conf_floor_r, max_range_r, ref_bearing_r, max_offset_r;
  logic [31:0]      lim2_r;

  logic                       pipe_en;
  logic [15:0]                conf;
  logic signed [POS_BITS-1:0] px, py, pz;

  logic                       prep_valid;
  gate_flags_t                prep_flags;
  logic signed [CORDIC_W-1:0] prep_x, prep_y;
  logic [ANG_W-1:0]           prep_acc;

  logic                       cor_valid;
  gate_flags_t                cor_flags;
  logic [ANG_W-1:0]           cor_acc;

  logic                       ver_valid;
  verdict_t                   ver_result;
  verdict_t                   out_result;

  // Configuration registers; the squared range limit follows in the cycle after a range write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conf_floor_r  <= CONF_FLOOR_RESET;
      max_range_r   <= MAX_RANGE_RESET;
      ref_bearing_r <= REF_BEARING_RESET;
      max_offset_r  <= MAX_OFFSET_RESET;
      lim2_r        <= LIM2_RESET;
    end else begin
      lim2_r <= 32'(max_range_r) * 32'(max_range_r);
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_CONF_FLOOR:  conf_floor_r  <= cfg_wdata;
          REG_MAX_RANGE:   max_range_r   <= cfg_wdata;
          REG_REF_BEARING: ref_bearing_r <= cfg_wdata;
          REG_MAX_OFFSET:  max_offset_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Unpack the input transaction.
  assign conf = in_tdata[15:0];
  assign px   = in_tdata[16 +: POS_BITS];
  assign py   = in_tdata[16 + POS_BITS +: POS_BITS];
  assign pz   = in_tdata[16 + 2 * POS_BITS +: POS_BITS];

  assign in_tready = pipe_en;

  rbtg_prep #(
    .POS_BITS (POS_BITS),
    .W        (CORDIC_W)
  ) u_prep (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (pipe_en),
    .valid_i      (in_tvalid),
    .conf_i       (conf),
    .px_i         (px),
    .py_i         (py),
    .pz_i         (pz),
    .conf_floor_i (conf_floor_r),
    .lim2_i       (lim2_r),
    .valid_o      (prep_valid),
    .flags_o      (prep_flags),
    .x_o          (prep_x),
    .y_o          (prep_y),
    .acc_o        (prep_acc)
  );

  rbtg_cordic #(
    .W      (CORDIC_W),
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (pipe_en),
    .valid_i (prep_valid),
    .flags_i (prep_flags),
    .x_i     (prep_x),
    .y_i     (prep_y),
    .acc_i   (prep_acc),
    .valid_o (cor_valid),
    .flags_o (cor_flags),
    .acc_o   (cor_acc)
  );

  rbtg_verdict u_verdict (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (pipe_en),
    .valid_i       (cor_valid),
    .flags_i       (cor_flags),
    .acc_i         (cor_acc),
    .ref_bearing_i (ref_bearing_r),
    .max_offset_i  (max_offset_r),
    .valid_o       (ver_valid),
    .result_o      (ver_result)
  );

  rbtg_outbuf u_outbuf (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_valid_i (ver_valid),
    .push_data_i  (ver_result),
    .ready_o      (pipe_en),
    .out_valid_o  (out_tvalid),
    .out_ready_i  (out_tready),
    .out_data_o   (out_result)
  );

  // Pack the result transaction.
  assign out_tdata = {5'd0, out_result.bearing_offset, out_result.reject_cause,
                      out_result.accepted};

endmodule

// File: src/rbtg_checker.sv
// Port-level checks for the range and bearing target gate, bound to the top level.
// Depends on rbtg_pkg and on the top-level module range_bearing_target_gate.
module rbtg_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [rbtg_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import rbtg_pkg::*;

  // A held result stays put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  // The accepted flag agrees with the reject cause.
  a_accept_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tdata[2:1] == CAUSE_NONE)))
    else $error("accepted flag disagrees with reject cause");

  // The wrapped offset never exceeds half a turn, and the padding stays zero.
  a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[18:3] <= 16'h8000) && (out_tdata[23:19] == 5'd0))
    else $error("bearing offset out of range or padding set");

  // The input side only stalls while a result is waiting at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result waiting");

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind range_bearing_target_gate rbtg_checker u_rbtg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for range_bearing_target_gate: stream stimulus and a verdict scoreboard.
// Depends on rbtg_pkg and the block's RTL; the scoreboard predicts every verdict on its own.

// One expected verdict, held until the block delivers its result.
typedef struct {
  logic        accepted;
  logic [1:0]  cause;
  logic [15:0] offset;
} gate_verdict_t;

// Gate predictor and in-order store of expected verdicts.
class gate_scoreboard;
  logic [15:0]   conf_floor;
  logic [15:0]   max_range;
  logic [15:0]   ref_yaw;
  logic [15:0]   max_offset;
  gate_verdict_t pending[$];
  int            errors;

  function new();
    conf_floor = rbtg_pkg::CONF_FLOOR_RESET;
    max_range  = rbtg_pkg::MAX_RANGE_RESET;
    ref_yaw    = rbtg_pkg::REF_BEARING_RESET;
    max_offset = rbtg_pkg::MAX_OFFSET_RESET;
    errors     = 0;
  endfunction

  // Mirror of a register write; only done while the block is idle.
  function void set_reg(logic [rbtg_pkg::CFG_ADDR_W-1:0] idx, logic [15:0] val);
    case (idx)
      rbtg_pkg::REG_CONF_FLOOR:  conf_floor = val;
      rbtg_pkg::REG_MAX_RANGE:   max_range  = val;
      rbtg_pkg::REG_REF_BEARING: ref_yaw    = val;
      rbtg_pkg::REG_MAX_OFFSET:  max_offset = val;
      default: ;
    endcase
  endfunction

  // Vectoring CORDIC: atan2(py, px) in binary angle units, rounded to 16 bits.
  function logic [15:0] bearing_units(logic signed [15:0] px, logic signed [15:0] py);
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] xs;
    logic signed [63:0] ys;
    logic [31:0]        ang;
    logic [31:0]        rounded;
    if (px == 0 && py == 0) begin
      return 16'd0;
    end
    x = 64'(px);
    y = 64'(py);
    x = x <<< rbtg_pkg::GUARD_SHIFT;
    y = y <<< rbtg_pkg::GUARD_SHIFT;
    ang = '0;
    // Left half plane is turned by half a turn first.
    if (x < 0) begin
      x = -x;
      y = -y;
      ang = rbtg_pkg::ANGLE_HALF_TURN;
    end
    for (int i = 0; i < rbtg_pkg::CORDIC_STAGES_DEF && i < rbtg_pkg::ATAN_LEN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      // A zero y counts as not positive, so the angle goes down.
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        ang = ang + rbtg_pkg::ATAN_TAB[i];
      end else begin
        x = x - ys;
        y = y + xs;
        ang = ang - rbtg_pkg::ATAN_TAB[i];
      end
    end
    rounded = ang + 32'h0000_8000;
    return rounded[31:16];
  endfunction

  // Works out the verdict of an accepted target transaction and queues it.
  function void note_target(logic [15:0] conf, logic signed [15:0] px,
                            logic signed [15:0] py, logic signed [15:0] pz);
    logic signed [63:0] sx;
    logic signed [63:0] sy;
    logic signed [63:0] sz;
    logic [63:0]        dist2;
    logic [63:0]        lim2;
    logic [15:0]        diff;
    logic [16:0]        offset;
    gate_verdict_t      v;
    sx = 64'(px);
    sy = 64'(py);
    sz = 64'(pz);
    dist2 = sx * sx + sy * sy + sz * sz;
    lim2 = 64'(max_range) * 64'(max_range);
    // Wrapped yaw difference; exactly half a turn gives 32768.
    diff = bearing_units(px, py) - ref_yaw;
    offset = diff[15] ? 17'h10000 - 17'(diff) : 17'(diff);
    if (conf < conf_floor) begin
      v.cause = rbtg_pkg::CAUSE_CONF;
    end else if (dist2 > lim2) begin
      v.cause = rbtg_pkg::CAUSE_RANGE;
    end else if (offset > 17'(max_offset)) begin
      v.cause = rbtg_pkg::CAUSE_BEARING;
    end else begin
      v.cause = rbtg_pkg::CAUSE_NONE;
    end
    v.accepted = (v.cause == rbtg_pkg::CAUSE_NONE);
    v.offset = offset[15:0];
    pending.insert(pending.size(), v);
  endfunction

  // Compares one result transaction with the oldest expected verdict.
  function void check_verdict(logic [rbtg_pkg::OUT_TDATA_W-1:0] tdata);
    gate_verdict_t want;
    if (pending.size() == 0) begin
      $error("verdict with no target waiting: tdata %h", tdata);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (tdata[0] !== want.accepted) begin
      $error("accepted: expected %0d, actual %0d", want.accepted, tdata[0]);
      errors++;
    end
    if (tdata[2:1] !== want.cause) begin
      $error("reject_cause: expected %0d, actual %0d", want.cause, tdata[2:1]);
      errors++;
    end
    if (tdata[18:3] !== want.offset) begin
      $error("bearing_offset: expected %0d, actual %0d", want.offset, tdata[18:3]);
      errors++;
    end
    if (tdata[23:19] !== 5'd0) begin
      $error("padding: expected 0, actual %h", tdata[23:19]);
      errors++;
    end
  endfunction
endclass

module tb_top;
  import rbtg_pkg::*;

  localparam int LATENCY = CORDIC_STAGES_DEF + 5;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [63:0]            in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_W-1:0]       cfg_wdata;

  gate_scoreboard sb;
  int             send_idle_pct = 0;
  int             recv_idle_pct = 0;
  int             verdicts_seen = 0;

  always #4 clk = ~clk;

  range_bearing_target_gate dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Result monitor: every result transaction goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_verdict(out_tdata);
      verdicts_seen <= verdicts_seen + 1;
    end
  end

  // Receiver: random back-pressure, plus long hold-offs that fill the pipeline.
  initial begin : receiver
    int hold_left;
    int next_hold_at;
    hold_left = 0;
    next_hold_at = 150;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && verdicts_seen >= next_hold_at) begin
        hold_left = 200;
        next_hold_at = next_hold_at + 350;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offers one target and returns at the edge where it is accepted.
  task automatic send_target(logic [15:0] conf, logic [15:0] px, logic [15:0] py,
                             logic [15:0] pz);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {pz, py, px, conf};
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    sb.note_target(conf, px, py, pz);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    in_tvalid <= 1'b0;
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_gates(logic [15:0] conf, logic [15:0] range_mm, logic [15:0] yaw,
                           logic [15:0] offset);
    write_reg(REG_CONF_FLOOR, conf);
    write_reg(REG_MAX_RANGE, range_mm);
    write_reg(REG_REF_BEARING, yaw);
    write_reg(REG_MAX_OFFSET, offset);
  endtask

  // Stops offering and waits until every expected verdict has come back.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) begin
      @(posedge clk);
    end
    repeat (2) @(posedge clk);
  endtask

  // Random target: mostly inside the range and confidence gates, some at the range limit, some raw noise.
  task automatic random_target();
    logic [15:0] conf;
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] pz;
    logic [15:0] rim;
    int          lim;
    int          mode;
    mode = $urandom_range(99);
    if ($urandom_range(3) == 0) begin
      conf = 16'($urandom());
    end else begin
      conf = 16'($urandom_range(65535, sb.conf_floor));
    end
    px = '0;
    py = '0;
    pz = '0;
    if (mode < 25) begin
      px = 16'($urandom());
      py = 16'($urandom());
      pz = 16'($urandom());
    end else if (mode < 40) begin
      // One coordinate right at the range limit, give or take one.
      lim = int'(sb.max_range) - 1 + int'($urandom_range(2));
      if (lim > 32767) begin
        lim = 32767;
      end
      rim = $urandom_range(1) ? 16'(-lim) : 16'(lim);
      case ($urandom_range(2))
        0: px = rim;
        1: py = rim;
        default: pz = rim;
      endcase
    end else begin
      lim = int'(sb.max_range) / 2;
      px = 16'(int'($urandom_range(2 * lim)) - lim);
      py = 16'(int'($urandom_range(2 * lim)) - lim);
      pz = 16'(int'($urandom_range(2 * lim)) - lim);
    end
    send_target(conf, px, py, pz);
  endtask

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #2_000_000;
    $display("range_bearing_target_gate: mismatch");
    $finish;
  end

  initial begin : stimulus
    int spins;
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_wr_en = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: origin, extremes, left half plane, half a turn off, range edge.
    send_target(16'h0000, 16'sd0, 16'sd0, 16'sd0);
    send_target(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_target(16'hFFFF, 16'h8000, 16'h8000, 16'h8000);
    send_target(16'd100, 16'h8000, 16'sd0, 16'sd0);
    send_target(16'd100, -16'sd1000, 16'sd0, 16'sd0);
    send_target(16'd100, 16'sd0, 16'sd1000, 16'sd0);
    send_target(16'd100, 16'sd0, -16'sd1000, 16'sd0);
    send_target(16'd100, 16'sd1000, 16'sd0, 16'sd0);
    send_target(16'd100, -16'sd1000, 16'sd1, 16'sd0);
    send_target(16'd100, -16'sd1000, -16'sd1, 16'sd0);
    send_target(16'd100, 16'sd1, 16'sd1, 16'sd0);
    send_target(16'd100, 16'sd8000, 16'sd0, 16'sd0);
    send_target(16'd100, 16'sd8001, 16'sd0, 16'sd0);
    send_target(16'd100, 16'sd0, 16'sd0, -16'sd8000);
    wait_idle();

    // Confidence edge, cause precedence and a narrow bearing window.
    set_gates(16'h8000, 16'hFFFF, 16'h4000, 16'd1000);
    send_target(16'h7FFF, 16'sd0, 16'sd1000, 16'sd0);
    send_target(16'h8000, 16'sd0, 16'sd1000, 16'sd0);
    send_target(16'h8000, 16'sd1000, 16'sd1000, 16'sd0);
    send_target(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_target(16'h0000, 16'h8000, 16'h8000, 16'sd0);
    send_target(16'hFFFF, 16'sd200, 16'sd1000, 16'h7FFF);

    // Random phases over several settings, extremes among them.
    for (int p = 0; p < 7; p++) begin
      wait_idle();
      case (p)
        0: set_gates(16'h4000, 16'd20000, 16'hE000, 16'd8192);
        1: set_gates(16'hFFFF, 16'd0, 16'h7FFF, 16'd0);
        2: set_gates(16'h0000, 16'hFFFF, 16'h8000, 16'h8000);
        3: set_gates(16'($urandom()), 16'($urandom()), 16'($urandom()),
                     16'($urandom_range(32768)));
        4: set_gates(16'($urandom()), 16'd30000, 16'($urandom()), 16'hFFFF);
        default: set_gates(16'($urandom()), 16'($urandom()), 16'($urandom()),
                           16'($urandom_range(40000)));
      endcase
      send_idle_pct = (p < 2) ? 12 : (p < 4) ? 55 : 0;
      recv_idle_pct = (p < 2) ? 55 : (p < 4) ? 12 : 0;
      repeat (100) random_target();
    end

    // Drain with a bound, then let any stray results show up.
    @(negedge clk);
    in_tvalid <= 1'b0;
    spins = 0;
    while (sb.pending.size() != 0 && spins < 5000) begin
      @(posedge clk);
      spins++;
    end
    repeat (LATENCY + 5) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $error("%0d verdicts never arrived", sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("range_bearing_target_gate: match");
    end else begin
      $display("range_bearing_target_gate: mismatch");
    end
    $finish;
  end

endmodule
